### rtl/mcf_pkg.sv
// Package with the shared types and constants of the MIMO complex FIR filter.
package mcf_pkg;

    localparam int MAX_ANT = 2;
    localparam int ACC_W   = 37;

    typedef struct packed {
        logic signed [15:0] im;
        logic signed [15:0] re;
    } cplx_t;

    typedef cplx_t [MAX_ANT-1:0] vec_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] im;
        logic signed [ACC_W-1:0] re;
    } sum_t;

    typedef sum_t [MAX_ANT-1:0] acc_t;

    // Per-cycle control broadcast along the row of cells.
    typedef struct packed {
        logic        wr_en;
        logic [2:0]  tap;
        logic        rx;
        logic        tx;
        cplx_t       coef;
        logic        shift;
        logic        clear;
    } ctl_t;

endpackage

### rtl/mcf_cell.sv
// One tap cell: coefficient matrix, delayed sample, products and partial sum.
module mcf_cell
    import mcf_pkg::*;
#(
    parameter int NUM_TX = 2,
    parameter int NUM_RX = 2,
    parameter int TAP    = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  ctl_t ctl,
    input  vec_t x_in,
    output vec_t x_out,
    input  acc_t acc_in,
    output acc_t acc_out
);

    vec_t               hist_reg;
    vec_t               hist_next;
    cplx_t              coef_reg [MAX_ANT][MAX_ANT];
    logic signed [31:0] prod_reg [MAX_ANT][MAX_ANT][4];
    acc_t               acc_reg;
    acc_t               acc_next;

    // The first cell always takes the new sample; the others are cleared at a block start.
    always_comb
    begin
        hist_next = hist_reg;
        if (ctl.shift)
        begin
            if (ctl.clear && (TAP != 0))
                hist_next = '0;
            else
                hist_next = x_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else
            hist_reg <= hist_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && (int'(ctl.tap) == TAP) && (int'(ctl.rx) < NUM_RX)
            && (int'(ctl.tx) < NUM_TX))
            coef_reg[ctl.rx][ctl.tx] <= ctl.coef;
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < MAX_ANT; r++)
        begin
            for (int t = 0; t < MAX_ANT; t++)
            begin
                if (r < NUM_RX && t < NUM_TX)
                begin
                    prod_reg[r][t][0] <= coef_reg[r][t].re * hist_reg[t].re;
                    prod_reg[r][t][1] <= coef_reg[r][t].im * hist_reg[t].im;
                    prod_reg[r][t][2] <= coef_reg[r][t].re * hist_reg[t].im;
                    prod_reg[r][t][3] <= coef_reg[r][t].im * hist_reg[t].re;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                        prod_reg[r][t][k] <= '0;
                end
            end
        end
    end

    always_comb
    begin
        acc_next = acc_in;
        for (int r = 0; r < MAX_ANT; r++)
        begin
            for (int t = 0; t < MAX_ANT; t++)
            begin
                acc_next[r].re = acc_next[r].re + ACC_W'(prod_reg[r][t][0])
                                 - ACC_W'(prod_reg[r][t][1]);
                acc_next[r].im = acc_next[r].im + ACC_W'(prod_reg[r][t][2])
                                 + ACC_W'(prod_reg[r][t][3]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign x_out   = hist_reg;
    assign acc_out = acc_reg;

endmodule

### rtl/mimo_complex_fir_filter.sv
// Top level of the MIMO complex FIR filter: control, row of tap cells, output register.
//
//  channel | direction | tdata                          | tuser
//  s_*     | in        | tap,rx,tx,coef re/im,x0,x1     | func, block_start
//  m_*     | out       | y0 re/im, y1 re/im (37 b each) | none
//
// A coefficient item leaves input open and gives no result.
// A sample item first shifts the delay line, then the products are registered, and
// then the partial sum ripples through the accumulator register of each cell in the row.
// Input is not taken while a sample is in the cells; a finished result waits in the
// output register, and a stalled output holds the cells until it is free.
// Reset clears the sample history and control; coefficients are undefined until written.
module mimo_complex_fir_filter
    import mcf_pkg::*;
#(
    parameter int NUM_TAPS = 8,
    parameter int NUM_TX   = 2,
    parameter int NUM_RX   = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tap_index[2:0], rx_index[3], tx_index[4], coef_re[20:5], coef_im[36:21],
    // x0_re[52:37], x0_im[68:53], x1_re[84:69], x1_im[100:85], zero pad
    input  logic [103:0] s_tdata,
    // func[0], block_start[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // y0_re[36:0], y0_im[73:37], y1_re[110:74], y1_im[147:111], zero pad
    output logic [151:0] m_tdata
);

    localparam int LAST  = NUM_TAPS + 1;
    localparam int CNT_W = $clog2(LAST + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    acc_t             out_reg;
    logic             s_fire, done, load;
    ctl_t             ctl;
    vec_t             x_new;
    vec_t             x_chain [NUM_TAPS+1];
    acc_t             acc_chain [NUM_TAPS+1];

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign done     = busy_reg && (cnt_reg == CNT_W'(LAST));
    assign load     = done && (!out_valid_reg || m_tready);

    always_comb
    begin
        x_new[0].re = s_tdata[52:37];
        x_new[0].im = s_tdata[68:53];
        x_new[1].re = (NUM_TX > 1) ? s_tdata[84:69]  : 16'sd0;
        x_new[1].im = (NUM_TX > 1) ? s_tdata[100:85] : 16'sd0;
        ctl.wr_en   = s_fire && !s_tuser[0];
        ctl.tap     = s_tdata[2:0];
        ctl.rx      = s_tdata[3];
        ctl.tx      = s_tdata[4];
        ctl.coef.re = s_tdata[20:5];
        ctl.coef.im = s_tdata[36:21];
        ctl.shift   = s_fire && s_tuser[0];
        ctl.clear   = s_tuser[1];
    end

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (ctl.shift)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (load)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        else if (busy_reg && !done)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= acc_chain[NUM_TAPS];
    end

    assign x_chain[0]   = x_new;
    assign acc_chain[0] = '0;

    for (genvar d = 0; d < NUM_TAPS; d++)
    begin : g_cell
        mcf_cell #(
            .NUM_TX (NUM_TX),
            .NUM_RX (NUM_RX),
            .TAP    (d)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .x_in    (x_chain[d]),
            .x_out   (x_chain[d+1]),
            .acc_in  (acc_chain[d]),
            .acc_out (acc_chain[d+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg[1].im, out_reg[1].re, out_reg[0].im, out_reg[0].re};

endmodule

### rtl/mcf_checker.sv
// Port-level checker for the MIMO complex FIR filter, bound to the top level.
module mcf_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    // A sample item occupies the cells, so input closes straight after it.
    a_sample_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
        else $error("input still open after a sample item");

    // A coefficient item is written straight into its cell and leaves input open.
    a_coef_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
        else $error("input closed after a coefficient item");

    // No result can appear the cycle after a sample is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind mimo_complex_fir_filter mcf_checker u_mcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
